// ----- sv/release_time_packet_queue_macros.svh -----
// Assertion macros for the release-time packet queue checker.
// Used by rtpq_checker.sv; depends on nothing else.
`ifndef RELEASE_TIME_PACKET_QUEUE_MACROS_SVH
`define RELEASE_TIME_PACKET_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtpq assertion failed");

// Next-cycle implication, disabled during reset.
`define RTPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtpq assertion failed");

`endif

// ----- sv/rtpq_pkg.sv -----
// Shared types and constants of the release-time packet queue.
// Used by rtpq_cell and release_time_packet_queue; depends on nothing.
`default_nettype none

package rtpq_pkg;

    localparam int CNT_W   = 7;
    localparam int BYTES_W = 24;
    localparam int LEN_W   = 16;
    localparam int HND_W   = 32;
    localparam int SEQ_W   = 32;

    localparam logic [CNT_W-1:0]   PKT_LIMIT_RST  = 7'd64;
    localparam logic [BYTES_W-1:0] BYTE_LIMIT_RST = 24'd1048576;

    localparam logic REG_PKT_LIMIT  = 1'b0;
    localparam logic REG_BYTE_LIMIT = 1'b1;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_TAKE
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [HND_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- sv/rtpq_cell.sv -----
// One cell of the sorted chain: holds a single packet descriptor.
// Depends on rtpq_pkg for the entry and control types.
`default_nettype none

module rtpq_cell #(
    parameter int TIME_BITS = 48
) (
    input  wire                          i_clk,
    input  wire rtpq_pkg::t_cell_ctrl    i_ctrl,
    input  wire                          i_valid,
    input  wire  [TIME_BITS-1:0]         i_key,
    input  wire rtpq_pkg::t_entry        i_new_ent,
    input  wire                          i_prev_gt,
    input  wire  [TIME_BITS-1:0]         i_prev_rel,
    input  wire rtpq_pkg::t_entry        i_prev_ent,
    input  wire  [TIME_BITS-1:0]         i_next_rel,
    input  wire rtpq_pkg::t_entry        i_next_ent,
    output logic                         o_gt,
    output logic [TIME_BITS-1:0]         o_rel,
    output rtpq_pkg::t_entry             o_ent
);
    import rtpq_pkg::*;

    logic [TIME_BITS-1:0] r_rel;
    t_entry               r_ent;

    // An empty cell counts as later than any key, so a push lands there.
    assign o_gt  = !i_valid || (r_rel > i_key);
    assign o_rel = r_rel;
    assign o_ent = r_ent;

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.pop) begin
            r_rel <= i_next_rel;
            r_ent <= i_next_ent;
        end else if (i_ctrl.ins && i_prev_gt) begin
            r_rel <= i_prev_rel;
            r_ent <= i_prev_ent;
        end else if (i_ctrl.ins && o_gt) begin
            r_rel <= i_key;
            r_ent <= i_new_ent;
        end else begin
            r_rel <= r_rel;
            r_ent <= r_ent;
        end
    end

endmodule

`default_nettype wire

// ----- sv/release_time_packet_queue.sv -----
// Top level of the release-time packet queue: command port, APB registers and cell chain.
// Depends on rtpq_pkg and rtpq_cell.
`default_nettype none

// Usage.
// An item is taken at a rising edge with start high and busy low. With i_action
// low it pushes a descriptor (handle, length, release time); with i_action high it
// takes every held packet whose release time is at or before i_now_time.
// Results appear on the o_ ports for one cycle each, marked by o_strobe, and
// cannot be held off.
// A push gives one result, registered from the push state; busy is high for one
// cycle. The new entry is placed by all cells comparing their release time with
// it and shifting in parallel. A take releases one due packet per cycle from the
// head of the chain; when none is due, it gives a single result marked not
// valid. Results are registered from the take state and then come one per cycle.
// The packet limit and the byte limit sit at byte addresses 0 and 4 of the APB
// port; the user must write them only while busy is low; the block does not enforce it.
// Reset clears the counts, the sequence number and the control state; cell
// contents are left as they are and count as empty.
module release_time_packet_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 48
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          i_action,
    input  wire  [TIME_BITS-1:0]         i_release_time,
    input  wire  [rtpq_pkg::LEN_W-1:0]   i_payload_length,
    input  wire  [rtpq_pkg::HND_W-1:0]   i_packet_handle,
    input  wire  [TIME_BITS-1:0]         i_now_time,
    output logic                         o_strobe,
    output logic                         o_accepted,
    output logic                         o_out_valid,
    output logic [rtpq_pkg::HND_W-1:0]   o_out_handle,
    output logic [rtpq_pkg::LEN_W-1:0]   o_out_length,
    output logic [TIME_BITS-1:0]         o_out_release,
    output logic [rtpq_pkg::SEQ_W-1:0]   o_out_sequence,
    output logic                         o_last_of_run,
    output logic [rtpq_pkg::CNT_W-1:0]   o_queued_packets,
    output logic [rtpq_pkg::BYTES_W-1:0] o_queued_bytes,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [2:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rtpq_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [BYTES_W-1:0]   r_bytes, n_bytes;
    logic [SEQ_W-1:0]     r_seqnext, n_seqnext;
    logic [CNT_W-1:0]     r_pkt_limit;
    logic [BYTES_W-1:0]   r_byte_limit;

    logic [TIME_BITS-1:0] r_key;
    logic [LEN_W-1:0]     r_len;
    logic [HND_W-1:0]     r_handle;

    logic                 n_strobe, n_accepted, n_out_valid, n_last;
    logic [HND_W-1:0]     n_out_handle;
    logic [LEN_W-1:0]     n_out_length;
    logic [TIME_BITS-1:0] n_out_release;
    logic [SEQ_W-1:0]     n_out_sequence;

    t_cell_ctrl           w_ctrl;
    t_entry               w_new_ent;
    logic                 w_push_ok;
    logic                 w_gt  [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] w_rel [QUEUE_DEPTH];
    t_entry               w_ent [QUEUE_DEPTH];
    logic                 w_accept;
    logic                 w_cfg_wr;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_PKT_LIMIT:  prdata = {{(32-CNT_W){1'b0}}, r_pkt_limit};
            REG_BYTE_LIMIT: prdata = {{(32-BYTES_W){1'b0}}, r_byte_limit};
            default:        prdata = '0;
        endcase
    end

    assign w_new_ent = '{seq: r_seqnext, len: r_len, handle: r_handle};

    assign w_push_ok = (r_len != '0)
        && ({{(BYTES_W-LEN_W){1'b0}}, r_len} <= r_byte_limit)
        && (32'(r_count) < 32'(r_pkt_limit))
        && (32'(r_count) < QUEUE_DEPTH)
        && (r_bytes <= r_byte_limit - {{(BYTES_W-LEN_W){1'b0}}, r_len});

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                 w_prev_gt;
            logic [TIME_BITS-1:0] w_prev_rel, w_next_rel;
            t_entry               w_prev_ent, w_next_ent;

            if (gi == 0) begin : g_head
                assign w_prev_gt  = 1'b0;
                assign w_prev_rel = '0;
                assign w_prev_ent = '0;
            end else begin : g_body
                assign w_prev_gt  = w_gt[gi-1];
                assign w_prev_rel = w_rel[gi-1];
                assign w_prev_ent = w_ent[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next_rel = '0;
                assign w_next_ent = '0;
            end else begin : g_mid
                assign w_next_rel = w_rel[gi+1];
                assign w_next_ent = w_ent[gi+1];
            end

            rtpq_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_valid    (gi < int'(r_count)),
                .i_key      (r_key),
                .i_new_ent  (w_new_ent),
                .i_prev_gt  (w_prev_gt),
                .i_prev_rel (w_prev_rel),
                .i_prev_ent (w_prev_ent),
                .i_next_rel (w_next_rel),
                .i_next_ent (w_next_ent),
                .o_gt       (w_gt[gi]),
                .o_rel      (w_rel[gi]),
                .o_ent      (w_ent[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_bytes        = r_bytes;
        n_seqnext      = r_seqnext;
        w_ctrl         = '0;
        n_strobe       = 1'b0;
        n_accepted     = 1'b0;
        n_out_valid    = 1'b0;
        n_out_handle   = '0;
        n_out_length   = '0;
        n_out_release  = '0;
        n_out_sequence = '0;
        n_last         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_action == ACT_TAKE) ? S_TAKE : S_PUSH;
                end
            end
            S_PUSH: begin
                w_ctrl.ins = w_push_ok;
                n_strobe   = 1'b1;
                n_accepted = w_push_ok;
                n_last     = 1'b1;
                n_state    = S_IDLE;
                if (w_push_ok) begin
                    n_count   = r_count + 1'b1;
                    n_bytes   = r_bytes + {{(BYTES_W-LEN_W){1'b0}}, r_len};
                    n_seqnext = r_seqnext + 1'b1;
                end
            end
            S_TAKE: begin
                n_strobe = 1'b1;
                if (!w_gt[0]) begin
                    w_ctrl.pop     = 1'b1;
                    n_out_valid    = 1'b1;
                    n_out_handle   = w_ent[0].handle;
                    n_out_length   = w_ent[0].len;
                    n_out_release  = w_rel[0];
                    n_out_sequence = w_ent[0].seq;
                    n_count        = r_count - 1'b1;
                    n_bytes        = r_bytes - {{(BYTES_W-LEN_W){1'b0}}, w_ent[0].len};
                    n_last         = w_gt[1];
                    if (w_gt[1]) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_bytes      <= '0;
            r_seqnext    <= '0;
            r_pkt_limit  <= PKT_LIMIT_RST;
            r_byte_limit <= BYTE_LIMIT_RST;
            o_strobe     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_bytes   <= n_bytes;
            r_seqnext <= n_seqnext;
            o_strobe  <= n_strobe;
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_PKT_LIMIT:  r_pkt_limit  <= pwdata[CNT_W-1:0];
                    REG_BYTE_LIMIT: r_byte_limit <= pwdata[BYTES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key    <= (i_action == ACT_TAKE) ? i_now_time : i_release_time;
            r_len    <= i_payload_length;
            r_handle <= i_packet_handle;
        end
        o_accepted       <= n_accepted;
        o_out_valid      <= n_out_valid;
        o_out_handle     <= n_out_handle;
        o_out_length     <= n_out_length;
        o_out_release    <= n_out_release;
        o_out_sequence   <= n_out_sequence;
        o_last_of_run    <= n_last;
        o_queued_packets <= n_count;
        o_queued_bytes   <= n_bytes;
    end

endmodule

`default_nettype wire

// ----- sv/rtpq_checker.sv -----
// Port-level checks of the release-time packet queue, bound to the top level.
// Depends on release_time_packet_queue_macros.svh.
`default_nettype none
`include "release_time_packet_queue_macros.svh"

module rtpq_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire start,
    input wire busy,
    input wire o_strobe,
    input wire o_accepted,
    input wire o_out_valid,
    input wire o_last_of_run
);

    `RTPQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `RTPQ_ASSERT_IMP(a_run_keeps_busy, i_clk, i_rst_n, o_strobe && !o_last_of_run, busy)
    `RTPQ_ASSERT_IMP(a_last_frees, i_clk, i_rst_n, o_strobe && o_last_of_run, !busy)
    `RTPQ_ASSERT_IMP(a_push_result, i_clk, i_rst_n, o_strobe && o_accepted, !o_out_valid && o_last_of_run)

endmodule

bind release_time_packet_queue rtpq_checker u_rtpq_checker (.*);

`default_nettype wire
